FILE: hdl/stsi_pkg.sv
`default_nettype none

package stsi_pkg;

    // Default table depth and the fixed widths of the transaction fields.
    localparam int TABLE_DEPTH_DEF = 128;
    localparam int KEY_W           = 32;
    localparam int POS_W           = 7;
    localparam int CNT_W           = 8;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic cmp_en;  // compare the incoming key and latch the flags
        logic wr_en;   // apply the insert step along the row
    } t_cell_ctl;

    // Flags that each cell latches when it compares.
    typedef struct packed {
        logic upper;   // entry is empty or not below the key
        logic eq;      // entry is valid and equal to the key
    } t_cell_flags;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             inserted;
        logic             table_full;
        logic [CNT_W-1:0] entries_now;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/stsi_ifs.sv
`default_nettype none

interface stsi_key_if;
    import stsi_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface stsi_res_if;
    import stsi_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;
    logic             inserted;
    logic             table_full;
    logic [CNT_W-1:0] entries_now;

    modport source (
        output valid, output found, output position, output inserted,
        output table_full, output entries_now, input ready
    );
    modport sink (
        input valid, input found, input position, input inserted,
        input table_full, input entries_now, output ready
    );
endinterface

`default_nettype wire

FILE: hdl/stsi_cell.sv
`default_nettype none

module stsi_cell
    import stsi_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_cell_ctl               i_ctl,
    input  wire logic                    i_valid,
    input  wire logic signed [KEY_W-1:0] i_cmp_key,
    input  wire logic signed [KEY_W-1:0] i_ins_key,
    input  wire logic signed [KEY_W-1:0] i_prev_entry,
    input  wire logic                    i_prev_upper,
    output logic signed [KEY_W-1:0]      o_entry,
    output t_cell_flags                  o_flags
);

    logic signed [KEY_W-1:0] r_entry;
    t_cell_flags             r_flags;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_flags.upper <= !i_valid || !(r_entry < i_cmp_key);
            r_flags.eq    <= i_valid && (r_entry == i_cmp_key);
        end
        // A cell at or above the insertion point takes the key if its lower
        // neighbour stays put, and otherwise takes the neighbour's entry.
        if (i_ctl.wr_en && r_flags.upper) begin
            r_entry <= i_prev_upper ? i_prev_entry : i_ins_key;
        end
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

FILE: hdl/sorted_table_search_insert.sv
`default_nettype none

// Sorted key table with lookup and insert. Each key transaction is compared in
// parallel against every entry of a row of cells; if the key is present the
// result reports found and its index, otherwise it is inserted at its sorted
// place with the entries above moving up one cell, or table_full is reported
// when all TABLE_DEPTH cells are occupied. The compare is latched in every
// cell at the accepting edge; on the next, the row shifts if the key is
// inserted and the result register loads. A new key is accepted only once
// the row has been updated and the result register is empty or being read.
// Positions and the entry count are reported modulo 128 and 256.
module sorted_table_search_insert
    import stsi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    stsi_key_if.sink    i_key_ch,
    stsi_res_if.source  o_res_ch
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state         r_state, n_state;
    logic [KEY_W-1:0] r_key;
    logic [CW-1:0]  r_count, n_count;
    logic           r_out_valid, n_out_valid;
    t_result        r_out, n_out;

    t_cell_ctl      cell_ctl;
    logic           key_ready;
    logic           key_accept;

    logic signed [KEY_W-1:0] entry_vec [TABLE_DEPTH];
    t_cell_flags             flag_vec  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  upper_vec;
    logic [TABLE_DEPTH-1:0]  eq_vec;
    logic [TABLE_DEPTH-1:0]  dest_vec;
    logic [TABLE_DEPTH-1:0]  valid_vec;

    logic           hit;
    logic           full;
    logic           do_insert;
    logic [IW-1:0]  eq_idx;
    logic [IW-1:0]  dest_idx;
    logic [IW+POS_W-1:0] pos_ext;
    logic [CW+CNT_W-1:0] cnt_ext;

    // ------------------------------------------------------------------
    // Row of cells
    // ------------------------------------------------------------------
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        localparam logic [CW-1:0] CellIdx = CW'(g);

        logic signed [KEY_W-1:0] prev_entry;
        logic                    prev_upper;

        if (g == 0) begin : g_first
            assign prev_entry = r_key;
            assign prev_upper = 1'b0;
        end else begin : g_rest
            assign prev_entry = entry_vec[g-1];
            assign prev_upper = upper_vec[g-1];
        end

        assign valid_vec[g] = CellIdx < r_count;

        stsi_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_valid      (valid_vec[g]),
            .i_cmp_key    (i_key_ch.key),
            .i_ins_key    (r_key),
            .i_prev_entry (prev_entry),
            .i_prev_upper (prev_upper),
            .o_entry      (entry_vec[g]),
            .o_flags      (flag_vec[g])
        );

        assign upper_vec[g] = flag_vec[g].upper;
        assign eq_vec[g]    = flag_vec[g].eq;
        assign dest_vec[g]  = flag_vec[g].upper && !prev_upper;
    end

    // Keys are unique in the table, so both vectors are at most one-hot and
    // an OR of the indices encodes them.
    always_comb begin
        eq_idx   = '0;
        dest_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (eq_vec[i]) begin
                eq_idx = eq_idx | IW'(i);
            end
            if (dest_vec[i]) begin
                dest_idx = dest_idx | IW'(i);
            end
        end
    end

    assign hit       = |eq_vec;
    assign full      = !hit && (r_count == CW'(TABLE_DEPTH));
    assign do_insert = !hit && !full;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (key_accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign key_accept = i_key_ch.valid && key_ready;

    always_comb begin
        key_ready       = 1'b0;
        cell_ctl.cmp_en = 1'b0;
        cell_ctl.wr_en  = 1'b0;
        n_count         = r_count;
        n_out_valid     = r_out_valid && !o_res_ch.ready;
        n_out           = r_out;
        pos_ext         = '0;
        cnt_ext         = '0;
        case (r_state)
            ST_IDLE: begin
                key_ready       = i_rst_n && (!r_out_valid || o_res_ch.ready);
                cell_ctl.cmp_en = key_ready;
            end
            ST_UPDATE: begin
                cell_ctl.wr_en = do_insert;
                if (do_insert) begin
                    n_count = r_count + CW'(1);
                end
                if (hit) begin
                    pos_ext = {{POS_W{1'b0}}, eq_idx};
                end else if (do_insert) begin
                    pos_ext = {{POS_W{1'b0}}, dest_idx};
                end
                cnt_ext             = {{CNT_W{1'b0}}, n_count};
                n_out_valid         = 1'b1;
                n_out.found         = hit;
                n_out.position      = pos_ext[POS_W-1:0];
                n_out.inserted      = do_insert;
                n_out.table_full    = full;
                n_out.entries_now   = cnt_ext[CNT_W-1:0];
            end
            default: begin
                key_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_accept) begin
            r_key <= i_key_ch.key;
        end
        r_out <= n_out;
    end

    assign i_key_ch.ready       = key_ready;
    assign o_res_ch.valid       = r_out_valid;
    assign o_res_ch.found       = r_out.found;
    assign o_res_ch.position    = r_out.position;
    assign o_res_ch.inserted    = r_out.inserted;
    assign o_res_ch.table_full  = r_out.table_full;
    assign o_res_ch.entries_now = r_out.entries_now;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds the table depth");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPDATE |-> $onehot0(eq_vec))
        else $error("more than one cell matches the key");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && do_insert) |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not advance the entry count");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_UPDATE))
        else $error("result presented without an update cycle");

endmodule

`default_nettype wire
